[design/psd_pkg.sv]
// Shared types and constants for the point-to-segment distance block.
// No dependencies; psd_front, psd_back and the top level import this package.
`timescale 1ns / 1ps

package psd_pkg;

  // Field and datapath widths (raw coordinate units throughout).
  localparam int unsigned InW    = 32;   // input coordinate
  localparam int unsigned DiffW  = 33;   // coordinate difference
  localparam int unsigned ProdW  = 66;   // product of two differences
  localparam int unsigned SumW   = 68;   // sum of three products, signed
  localparam int unsigned MagW   = 66;   // cross product magnitude
  localparam int unsigned HalfW  = 33;   // half of a magnitude for squaring
  localparam int unsigned NumW   = 132;  // squared cross product norm
  localparam int unsigned QuoW   = 66;   // squared distance
  localparam int unsigned RemW   = 67;   // divider partial remainder
  localparam int unsigned DistW  = 34;   // distance result
  localparam int unsigned RadW   = 2 * DistW;  // root radicand, padded
  localparam int unsigned SqRemW = DistW + 3;  // root partial remainder

  // Default queue depths.
  localparam int unsigned JobQDepth = 4;
  localparam int unsigned ResQDepth = 2;

  typedef enum logic [1:0] {
    REGION_INTERIOR = 2'd0,
    REGION_BEFORE   = 2'd1,
    REGION_PAST     = 2'd2,
    REGION_DEGEN    = 2'd3
  } region_e;

  // One input beat: point and segment endpoints.
  typedef struct packed {
    logic signed [InW-1:0] point_x;
    logic signed [InW-1:0] point_y;
    logic signed [InW-1:0] point_z;
    logic signed [InW-1:0] seg_start_x;
    logic signed [InW-1:0] seg_start_y;
    logic signed [InW-1:0] seg_start_z;
    logic signed [InW-1:0] seg_end_x;
    logic signed [InW-1:0] seg_end_y;
    logic signed [InW-1:0] seg_end_z;
  } psd_item_t;

  // One result beat.
  typedef struct packed {
    logic [DistW-1:0] dist_res;
    region_e          region;
  } psd_res_t;

  // Classified job handed from the front end to the back end.
  typedef struct packed {
    logic signed [DiffW-1:0] v0x;
    logic signed [DiffW-1:0] v0y;
    logic signed [DiffW-1:0] v0z;
    logic signed [DiffW-1:0] v1x;
    logic signed [DiffW-1:0] v1y;
    logic signed [DiffW-1:0] v1z;
    logic [QuoW-1:0]         den;     // divisor: squared length, or one
    logic [QuoW-1:0]         alt_d2;  // endpoint squared distance
    region_e                 region;
  } psd_job_t;

endpackage

[design/psd_fifo.sv]
// Small synchronous queue built from flip-flops.
// Depends on nothing; used between the front and back ends and at the output.
`timescale 1ns / 1ps

module psd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and occupancy update, wrapping at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[design/psd_front.sv]
// Front end: forms difference vectors and dot products and classifies the region.
// Depends on psd_pkg; feeds classified jobs into the job queue.
`timescale 1ns / 1ps

module psd_front
  import psd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  psd_item_t item_i,
  output logic      ready_o,
  input  logic      q_full_i,
  output logic      job_vld_o,
  output psd_job_t  job_o
);

  logic en, accept;
  logic s1_vld_q, s2_vld_q, s3_vld_q;

  logic signed [DiffW-1:0] v0_d [3], v1_d [3], w1_d [3];
  logic signed [DiffW-1:0] v0_q [3], v1_q [3], w1_q [3];
  logic signed [DiffW-1:0] v0_s2_q [3], v1_s2_q [3];
  logic signed [ProdW-1:0] dot_p_q [3], len_p_q [3], v1v1_q [3], w1w1_q [3];
  logic                    degen_q;
  logic signed [SumW-1:0]  dot, len2, vv1, ww1;
  psd_job_t                job_d, job_q;

  // The whole front end stalls only when its last beat cannot enter the queue.
  assign en        = !(s3_vld_q && q_full_i);
  assign ready_o   = en;
  assign accept    = push_i && en;
  assign job_vld_o = s3_vld_q;
  assign job_o     = job_q;

  // Stage 1: segment direction and point offsets from both endpoints.
  always_comb begin
    v0_d[0] = DiffW'(item_i.seg_end_x) - DiffW'(item_i.seg_start_x);
    v0_d[1] = DiffW'(item_i.seg_end_y) - DiffW'(item_i.seg_start_y);
    v0_d[2] = DiffW'(item_i.seg_end_z) - DiffW'(item_i.seg_start_z);
    v1_d[0] = DiffW'(item_i.point_x) - DiffW'(item_i.seg_start_x);
    v1_d[1] = DiffW'(item_i.point_y) - DiffW'(item_i.seg_start_y);
    v1_d[2] = DiffW'(item_i.point_z) - DiffW'(item_i.seg_start_z);
    w1_d[0] = DiffW'(item_i.point_x) - DiffW'(item_i.seg_end_x);
    w1_d[1] = DiffW'(item_i.point_y) - DiffW'(item_i.seg_end_y);
    w1_d[2] = DiffW'(item_i.point_z) - DiffW'(item_i.seg_end_z);
  end

  // Stage 3: sum the products and pick the region.
  always_comb begin
    dot  = SumW'(dot_p_q[0]) + SumW'(dot_p_q[1]) + SumW'(dot_p_q[2]);
    len2 = SumW'(len_p_q[0]) + SumW'(len_p_q[1]) + SumW'(len_p_q[2]);
    vv1  = SumW'(v1v1_q[0]) + SumW'(v1v1_q[1]) + SumW'(v1v1_q[2]);
    ww1  = SumW'(w1w1_q[0]) + SumW'(w1w1_q[1]) + SumW'(w1w1_q[2]);
    job_d.v0x    = v0_s2_q[0];
    job_d.v0y    = v0_s2_q[1];
    job_d.v0z    = v0_s2_q[2];
    job_d.v1x    = v1_s2_q[0];
    job_d.v1y    = v1_s2_q[1];
    job_d.v1z    = v1_s2_q[2];
    job_d.den    = QuoW'(1);
    job_d.alt_d2 = vv1[QuoW-1:0];
    if (degen_q) begin
      job_d.region = REGION_DEGEN;
    end else if (dot[SumW-1]) begin
      job_d.region = REGION_BEFORE;
    end else if (dot > len2) begin
      job_d.region = REGION_PAST;
      job_d.alt_d2 = ww1[QuoW-1:0];
    end else begin
      job_d.region = REGION_INTERIOR;
      job_d.den    = len2[QuoW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // Payload stages; stage 2 holds the twelve products and the vectors beside them.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v0_q[i]    <= v0_d[i];
        v1_q[i]    <= v1_d[i];
        w1_q[i]    <= w1_d[i];
        v0_s2_q[i] <= v0_q[i];
        v1_s2_q[i] <= v1_q[i];
        dot_p_q[i] <= v1_q[i] * v0_q[i];
        len_p_q[i] <= v0_q[i] * v0_q[i];
        v1v1_q[i]  <= v1_q[i] * v1_q[i];
        w1w1_q[i]  <= w1_q[i] * w1_q[i];
      end
      degen_q <= (v0_q[0] == '0) && (v0_q[1] == '0) && (v0_q[2] == '0);
      job_q   <= job_d;
    end
  end

endmodule

[design/psd_back.sv]
// Back end: cross product norm, pipelined restoring divider and square root.
// Depends on psd_pkg; takes jobs from the job queue, feeds the result queue.
`timescale 1ns / 1ps

module psd_back
  import psd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_vld_i,
  input  psd_job_t job_i,
  output logic     take_o,
  input  logic     out_full_i,
  output logic     res_vld_o,
  output psd_res_t res_o
);

  logic en;

  // Preparation stages.
  logic                    p1_vld_q, p2_vld_q, p3_vld_q, p4_vld_q;
  logic signed [ProdW-1:0] pa_q [3], pb_q [3];
  logic [MagW-1:0]         mag_d [3], mag_q [3];
  logic [ProdW-1:0]        hh_q [3], hl_q [3], ll_q [3];
  logic [NumW-1:0]         sq_q [3];
  logic [QuoW-1:0]         den1_q, den2_q, den3_q, den4_q;
  logic [QuoW-1:0]         alt1_q, alt2_q, alt3_q, alt4_q;
  region_e                 rg1_q, rg2_q, rg3_q, rg4_q;
  logic signed [DiffW-1:0] v0 [3], v1 [3];
  logic [NumW-1:0]         num_d;

  // Divider stages, one quotient bit each.
  logic            dv_vld_q [QuoW+1];
  logic [RemW-1:0] dv_rem_q [QuoW+1];
  logic [QuoW-1:0] dv_lo_q  [QuoW+1];
  logic [QuoW-1:0] dv_den_q [QuoW+1];
  logic [QuoW-1:0] dv_quo_q [QuoW+1];
  region_e         dv_rg_q  [QuoW+1];

  // Root stages, one result bit each.
  logic              sr_vld_q  [DistW+1];
  logic [SqRemW-1:0] sr_rem_q  [DistW+1];
  logic [RadW-1:0]   sr_rad_q  [DistW+1];
  logic [DistW-1:0]  sr_root_q [DistW+1];
  region_e           sr_rg_q   [DistW+1];

  // One stall signal: the whole back end holds while the last stage has a result and the result queue is full.
  assign en         = !(res_vld_o && out_full_i);
  assign take_o     = en && job_vld_i;
  assign res_vld_o  = sr_vld_q[DistW];
  assign res_o.dist_res = sr_root_q[DistW];
  assign res_o.region   = sr_rg_q[DistW];

  assign v0[0] = job_i.v0x;
  assign v0[1] = job_i.v0y;
  assign v0[2] = job_i.v0z;
  assign v1[0] = job_i.v1x;
  assign v1[1] = job_i.v1y;
  assign v1[2] = job_i.v1z;

  // Cross product components and their magnitudes.
  always_comb begin
    logic signed [ProdW:0] c;
    for (int i = 0; i < 3; i++) begin
      c        = (ProdW + 1)'(pa_q[i]) - (ProdW + 1)'(pb_q[i]);
      mag_d[i] = c[ProdW] ? MagW'(-c) : MagW'(c);
    end
  end

  // Divider input: the cross norm for the interior, else the endpoint distance.
  always_comb begin
    if (rg4_q == REGION_INTERIOR) begin
      num_d = sq_q[0] + sq_q[1] + sq_q[2];
    end else begin
      num_d = NumW'(alt4_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q    <= 1'b0;
      p2_vld_q    <= 1'b0;
      p3_vld_q    <= 1'b0;
      p4_vld_q    <= 1'b0;
      dv_vld_q[0] <= 1'b0;
    end else if (en) begin
      p1_vld_q    <= job_vld_i;
      p2_vld_q    <= p1_vld_q;
      p3_vld_q    <= p2_vld_q;
      p4_vld_q    <= p3_vld_q;
      dv_vld_q[0] <= p4_vld_q;
    end
  end

  // Preparation payload: products, magnitudes, split squares, sums.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa_q[i]  <= v1[(i + 1) % 3] * v0[(i + 2) % 3];
        pb_q[i]  <= v1[(i + 2) % 3] * v0[(i + 1) % 3];
        mag_q[i] <= mag_d[i];
        hh_q[i]  <= mag_q[i][MagW-1:HalfW] * mag_q[i][MagW-1:HalfW];
        hl_q[i]  <= mag_q[i][MagW-1:HalfW] * mag_q[i][HalfW-1:0];
        ll_q[i]  <= mag_q[i][HalfW-1:0] * mag_q[i][HalfW-1:0];
        sq_q[i]  <= (NumW'(hh_q[i]) << (2 * HalfW)) + (NumW'(hl_q[i]) << (HalfW + 1))
                    + NumW'(ll_q[i]);
      end
      den1_q <= job_i.den;
      den2_q <= den1_q;
      den3_q <= den2_q;
      den4_q <= den3_q;
      alt1_q <= job_i.alt_d2;
      alt2_q <= alt1_q;
      alt3_q <= alt2_q;
      alt4_q <= alt3_q;
      rg1_q  <= job_i.region;
      rg2_q  <= rg1_q;
      rg3_q  <= rg2_q;
      rg4_q  <= rg3_q;
      dv_rem_q[0] <= RemW'(num_d[NumW-1:QuoW]);
      dv_lo_q[0]  <= num_d[QuoW-1:0];
      dv_den_q[0] <= den4_q;
      dv_quo_q[0] <= '0;
      dv_rg_q[0]  <= rg4_q;
    end
  end

  // Restoring division, one trial subtraction per stage.
  for (genvar k = 0; k < QuoW; k++) begin : g_div
    logic [RemW-1:0] trial;
    logic [RemW:0]   diff;
    logic            ge;

    assign trial = {dv_rem_q[k][RemW-2:0], dv_lo_q[k][QuoW-1]};
    assign diff  = {1'b0, trial} - (RemW + 1)'(dv_den_q[k]);
    assign ge    = !diff[RemW];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rem_q[k+1] <= ge ? diff[RemW-1:0] : trial;
        dv_lo_q[k+1]  <= {dv_lo_q[k][QuoW-2:0], 1'b0};
        dv_den_q[k+1] <= dv_den_q[k];
        dv_quo_q[k+1] <= {dv_quo_q[k][QuoW-2:0], ge};
        dv_rg_q[k+1]  <= dv_rg_q[k];
      end
    end
  end

  // Root stage zero loads the quotient as the radicand.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_vld_q[0] <= 1'b0;
    end else if (en) begin
      sr_vld_q[0] <= dv_vld_q[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_rem_q[0]  <= '0;
      sr_rad_q[0]  <= RadW'(dv_quo_q[QuoW]);
      sr_root_q[0] <= '0;
      sr_rg_q[0]   <= dv_rg_q[QuoW];
    end
  end

  // Digit-by-digit square root, two radicand bits per stage.
  for (genvar k = 0; k < DistW; k++) begin : g_root
    logic [SqRemW-1:0] cur, trial;
    logic [SqRemW:0]   diff;
    logic              ge;

    assign cur   = {sr_rem_q[k][SqRemW-3:0], sr_rad_q[k][RadW-1 -: 2]};
    assign trial = {1'b0, sr_root_q[k], 2'b01};
    assign diff  = {1'b0, cur} - {1'b0, trial};
    assign ge    = !diff[SqRemW];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_vld_q[k+1] <= 1'b0;
      end else if (en) begin
        sr_vld_q[k+1] <= sr_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_rem_q[k+1]  <= ge ? diff[SqRemW-1:0] : cur;
        sr_rad_q[k+1]  <= {sr_rad_q[k][RadW-3:0], 2'b00};
        sr_root_q[k+1] <= {sr_root_q[k][DistW-2:0], ge};
        sr_rg_q[k+1]   <= sr_rg_q[k];
      end
    end
  end

  // An endpoint or degenerate job must reach the divider with a unit divisor.
  a_unit_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld_q[0] && dv_rg_q[0] != REGION_INTERIOR) |-> (dv_den_q[0] == QuoW'(1)))
    else $error("non-interior job has a divisor other than one");

  // The divider never starts with a remainder at or above its divisor.
  a_div_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld_q[0] |-> (dv_rem_q[0] < RemW'(dv_den_q[0])))
    else $error("quotient would overflow the divider");

  // A full result queue freezes the last root stage.
  a_tail_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_o && out_full_i) |=> (res_vld_o && $stable(sr_root_q[DistW])))
    else $error("result left the back end while stalled");

endmodule

[design/point_segment_distance.sv]
// Top level of the point-to-segment distance block.
// Depends on psd_pkg, psd_front, psd_fifo and psd_back.
`timescale 1ns / 1ps

// Returns the truncated Euclidean distance from a 3D point to a closed segment,
// in the raw units of the Q16.16 inputs, together with the region the point's
// projection falls in. The block takes one beat per clock while full is low and
// keeps no state between beats. A beat passes through the front-end stages, the
// job queue, the preparation stages, the divider stages (one quotient bit per
// stage), the root stages (one result bit per stage) and the result queue.
// Front and back ends stall independently through the job queue; full rises
// only when the front end's last stage cannot enter that queue, and the back
// end stalls only when the result queue is full.

module point_segment_distance
  import psd_pkg::*;
#(
  parameter int unsigned JOB_Q_DEPTH = JobQDepth,
  parameter int unsigned RES_Q_DEPTH = ResQDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  psd_item_t item_i,
  output logic      empty,
  input  logic      pop,
  output psd_res_t  result_o
);

  logic     front_ready, job_vld, job_full, job_empty, job_push, job_take;
  psd_job_t front_job, queued_job;
  logic     res_vld, res_full, res_push;
  psd_res_t back_res;
  logic [$bits(psd_job_t)-1:0] job_rdata;
  logic [$bits(psd_res_t)-1:0] res_rdata;

  assign full     = !front_ready;
  assign job_push = job_vld && !job_full;
  assign res_push = res_vld && !res_full;
  assign queued_job = psd_job_t'(job_rdata);
  assign result_o   = psd_res_t'(res_rdata);

  // Front end: differences, dot products and region.
  psd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .item_i    (item_i),
    .ready_o   (front_ready),
    .q_full_i  (job_full),
    .job_vld_o (job_vld),
    .job_o     (front_job)
  );

  // Queue between the front and back ends.
  psd_fifo #(
    .WIDTH ($bits(psd_job_t)),
    .DEPTH (JOB_Q_DEPTH)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (front_job),
    .full_o  (job_full),
    .pop_i   (job_take),
    .rdata_o (job_rdata),
    .empty_o (job_empty)
  );

  // Back end: cross norm, divider and root.
  psd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_vld_i  (!job_empty),
    .job_i      (queued_job),
    .take_o     (job_take),
    .out_full_i (res_full),
    .res_vld_o  (res_vld),
    .res_o      (back_res)
  );

  // Result queue seen by the consumer.
  psd_fifo #(
    .WIDTH ($bits(psd_res_t)),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  // A finished front-end beat waiting on a full queue must not be dropped.
  a_job_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_vld && job_full) |=> job_vld)
    else $error("front-end beat lost while the job queue was full");

  // The back end never takes a job from an empty queue.
  a_take_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_take |-> !job_empty)
    else $error("back end took a beat from an empty job queue");

  // A finished result waiting on a full result queue must not be dropped.
  a_res_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld && res_full) |=> res_vld)
    else $error("result beat lost while the result queue was full");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for point_segment_distance.
// Depends on psd_pkg and the block's RTL; uses a predictor of exact integer geometry.
`timescale 1ns / 1ps

module tb_top;
  import psd_pkg::*;

  localparam int unsigned NumRandom  = 700;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 200;

  typedef logic signed [135:0] wide_t;

  // One row of the directed table; typed marks rows with a hand-written answer.
  typedef struct {
    psd_item_t        query;
    bit               typed;
    logic [DistW-1:0] dist_val;
    region_e          region;
  } query_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      full;
  psd_item_t item_i = '0;
  logic      empty;
  logic      pop = 1'b0;
  psd_res_t  result_o;

  psd_res_t   dist_expect_q[$];
  query_row_t query_table[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          rand_started = 1'b0;

  point_segment_distance dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  always #1 clk_i = ~clk_i;

  // Dot product of two difference vectors at full width.
  function automatic wide_t dot3(longint a0, longint a1, longint a2,
                                 longint b0, longint b1, longint b2);
    wide_t x0, x1, x2, y0, y1, y2;
    x0 = a0; x1 = a1; x2 = a2;
    y0 = b0; y1 = b1; y2 = b2;
    return x0 * y0 + x1 * y1 + x2 * y2;
  endfunction

  // Truncated square root of a squared distance below 2^68.
  function automatic logic [DistW-1:0] isqrt(wide_t sq);
    logic [DistW-1:0] root;
    logic [DistW-1:0] cand;
    wide_t            cw;
    root = '0;
    for (int b = DistW - 1; b >= 0; b--) begin
      cand = root | (DistW'(1) << b);
      cw = {102'd0, cand};
      if (cw * cw <= sq) root = cand;
    end
    return root;
  endfunction

  // Distance from the point to the closed segment, and the projection region.
  function automatic psd_res_t calc_distance(psd_item_t q);
    longint v0[3], v1[3], w1[3];
    wide_t  dot, len2, d2, c0, c1, c2, a, b;
    psd_res_t res;
    v0[0] = longint'(q.seg_end_x) - longint'(q.seg_start_x);
    v0[1] = longint'(q.seg_end_y) - longint'(q.seg_start_y);
    v0[2] = longint'(q.seg_end_z) - longint'(q.seg_start_z);
    v1[0] = longint'(q.point_x) - longint'(q.seg_start_x);
    v1[1] = longint'(q.point_y) - longint'(q.seg_start_y);
    v1[2] = longint'(q.point_z) - longint'(q.seg_start_z);
    w1[0] = longint'(q.point_x) - longint'(q.seg_end_x);
    w1[1] = longint'(q.point_y) - longint'(q.seg_end_y);
    w1[2] = longint'(q.point_z) - longint'(q.seg_end_z);
    dot  = dot3(v1[0], v1[1], v1[2], v0[0], v0[1], v0[2]);
    len2 = dot3(v0[0], v0[1], v0[2], v0[0], v0[1], v0[2]);
    if (len2 == 0) begin
      res.region = REGION_DEGEN;
      d2 = dot3(v1[0], v1[1], v1[2], v1[0], v1[1], v1[2]);
    end else if (dot < 0) begin
      res.region = REGION_BEFORE;
      d2 = dot3(v1[0], v1[1], v1[2], v1[0], v1[1], v1[2]);
    end else if (dot > len2) begin
      res.region = REGION_PAST;
      d2 = dot3(w1[0], w1[1], w1[2], w1[0], w1[1], w1[2]);
    end else begin
      // Interior: squared cross product norm over squared length, truncated.
      a = v1[1]; b = v0[2]; c0 = a * b; a = v1[2]; b = v0[1]; c0 = c0 - a * b;
      a = v1[2]; b = v0[0]; c1 = a * b; a = v1[0]; b = v0[2]; c1 = c1 - a * b;
      a = v1[0]; b = v0[1]; c2 = a * b; a = v1[1]; b = v0[0]; c2 = c2 - a * b;
      res.region = REGION_INTERIOR;
      d2 = (c0 * c0 + c1 * c1 + c2 * c2) / len2;
    end
    res.dist_res = isqrt(d2);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatch_cnt++;
  endtask

  function automatic psd_item_t make_query(int px, int py, int pz, int sx, int sy, int sz,
                                           int ex, int ey, int ez);
    psd_item_t q;
    q.point_x = px; q.point_y = py; q.point_z = pz;
    q.seg_start_x = sx; q.seg_start_y = sy; q.seg_start_z = sz;
    q.seg_end_x = ex; q.seg_end_y = ey; q.seg_end_z = ez;
    return q;
  endfunction

  function automatic int rand_signed(int unsigned span);
    return int'($urandom_range(0, 2 * span)) - int'(span);
  endfunction

  // Random query: mostly small well-formed geometry, some full-range noise.
  function automatic psd_item_t gen_query();
    psd_item_t q;
    int unsigned mode;
    int unsigned span;
    mode = $urandom_range(0, 9);
    span = (mode == 9) ? 8 : (32'd1 << $urandom_range(4, 28));
    q = make_query(rand_signed(span), rand_signed(span), rand_signed(span),
                   rand_signed(span), rand_signed(span), rand_signed(span),
                   rand_signed(span), rand_signed(span), rand_signed(span));
    case (mode)
      0, 1: q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom};
      6: begin
        q.seg_end_x = q.seg_start_x; q.seg_end_y = q.seg_start_y;
        q.seg_end_z = q.seg_start_z;
      end
      7: begin
        q.point_z = '0; q.seg_start_z = '0; q.seg_end_z = '0;
      end
      8: begin
        // Point exactly at the start or the end of the segment.
        if ($urandom_range(0, 1)) begin
          q.point_x = q.seg_start_x; q.point_y = q.seg_start_y; q.point_z = q.seg_start_z;
        end else begin
          q.point_x = q.seg_end_x; q.point_y = q.seg_end_y; q.point_z = q.seg_end_z;
        end
      end
      default: ;
    endcase
    return q;
  endfunction

  // Offer one beat and hold it until accepted, then record its expectation.
  task automatic send_query(psd_item_t q, psd_res_t want);
    push <= 1'b1;
    item_i <= q;
    do @(posedge clk_i); while (full);
    dist_expect_q.push_back(want);
  endtask

  task automatic sender_gap();
    int unsigned k;
    int unsigned n;
    k = $urandom_range(0, 99);
    n = (k < 75) ? 0 : (k < 95) ? $urandom_range(1, 3) : $urandom_range(20, 60);
    if (n != 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Directed table: typed rows are simple enough to read off by hand.
  initial begin
    query_row_t row;
    psd_res_t   want;
    int mn;
    int mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    row.typed = 1'b1;
    row.query = make_query(0, 0, 0, 0, 0, 0, 0, 0, 0);
    row.dist_val = 0; row.region = REGION_DEGEN; query_table.push_back(row);
    row.query = make_query(1, 0, 0, 0, 0, 0, 0, 0, 0);
    row.dist_val = 1; row.region = REGION_DEGEN; query_table.push_back(row);
    row.query = make_query(-1, 0, 0, 0, 0, 0, 1, 0, 0);
    row.dist_val = 1; row.region = REGION_BEFORE; query_table.push_back(row);
    row.query = make_query(2, 0, 0, 0, 0, 0, 1, 0, 0);
    row.dist_val = 1; row.region = REGION_PAST; query_table.push_back(row);
    row.query = make_query(0, 4, 0, -1, 0, 0, 1, 0, 0);
    row.dist_val = 4; row.region = REGION_INTERIOR; query_table.push_back(row);
    row.query = make_query(0, 0, 0, 0, 0, 0, 0, 0, 1);
    row.dist_val = 0; row.region = REGION_INTERIOR; query_table.push_back(row);
    row.query = make_query(0, 0, 1, 0, 0, 0, 0, 0, 1);
    row.dist_val = 0; row.region = REGION_INTERIOR; query_table.push_back(row);
    row.typed = 1'b0;
    row.query = make_query(mx, mx, mx, mn, mn, mn, mn, mn, mn); query_table.push_back(row);
    row.query = make_query(mn, mn, mn, mx, mx, mx, mx, mx, mx); query_table.push_back(row);
    row.query = make_query(mn, mx, mn, mn, mn, mn, mx, mx, mx); query_table.push_back(row);
    row.query = make_query(0, 0, 0, mn, mn, mn, mx, mx, mx); query_table.push_back(row);
    row.query = make_query(mx, mn, 0, mn, mx, mn, mx, mn, mx); query_table.push_back(row);
    row.query = make_query(mn, mn, mn, mn, mn, mx, mx, mx, mn); query_table.push_back(row);
    row.query = make_query(mx, mx, mx, mn, mn, mn, mx, mx, mx); query_table.push_back(row);
    row.query = make_query(mn, mn, mn, mn, mn, mn, mx, mx, mx); query_table.push_back(row);
    row.query = make_query(3, 7, 0, 0, 0, 0, 10, 0, 0); query_table.push_back(row);
    row.query = make_query(-1, -1, -1, -1, -1, -1, -1, -1, -1); query_table.push_back(row);
    row.query = make_query(65536, 65536, 0, 0, 0, 0, 131072, 0, 0);
    query_table.push_back(row);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (query_table[i]) begin
      want = calc_distance(query_table[i].query);
      if (query_table[i].typed) begin
        want.dist_res = query_table[i].dist_val;
        want.region = query_table[i].region;
      end
      send_query(query_table[i].query, want);
      sender_gap();
    end

    // Random part; the receiver takes a long hold-off once it begins.
    rand_started = 1'b1;
    for (int n = 0; n < NumRandom; n++) begin
      psd_item_t q;
      q = gen_query();
      send_query(q, calc_distance(q));
      if (n == NumRandom / 2) begin
        push <= 1'b0;
        while (dist_expect_q.size() != 0) @(posedge clk_i);
      end else begin
        sender_gap();
      end
    end
    push <= 1'b0;

    while (dist_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: random pop gaps, bursts of steady pops, and one long hold-off.
  initial begin
    int unsigned k;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      k = $urandom_range(0, 99);
      if (rand_started && !held) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (600) @(posedge clk_i);
      end else if (k < 65) begin
        pop <= 1'b1;
        @(posedge clk_i);
      end else if (k < 70) begin
        pop <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk_i);
      end else if (k < 95) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        pop <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end
    end
  end

  // Result checker: each accepted beat against the oldest expectation.
  always @(posedge clk_i) begin
    psd_res_t want;
    if (rst_ni && pop && !empty) begin
      if (dist_expect_q.size() == 0) begin
        report_mismatch("unexpected result beat", result_o.dist_res, -1);
      end else begin
        want = dist_expect_q.pop_front();
        if (result_o.dist_res !== want.dist_res)
          report_mismatch("dist_res", result_o.dist_res, want.dist_res);
        if (result_o.region !== want.region)
          report_mismatch("region", result_o.region, want.region);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

[files.f]
design/psd_pkg.sv
design/psd_fifo.sv
design/psd_front.sv
design/psd_back.sv
design/point_segment_distance.sv
tb/tb_top.sv
